// ===== src/mbam_pkg.sv =====
`timescale 1ns / 1ps

package mbam_pkg;

  localparam int NUM_CLASSES = 4;
  localparam int CLS_AW      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  localparam logic [2:0]  LINEAR_CLASS = 3'd3;
  localparam logic [31:0] APP_RESERVE  = 32'd1048576;
  localparam logic [31:0] STACK_LIMIT  = 32'd65536;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_SAMPLE   = 2'd0;
  localparam logic [1:0] OP_ALLOC    = 2'd1;
  localparam logic [1:0] OP_FREE     = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int         PADDR_W = 5;
  localparam logic [2:0] REG_BASE_APP    = 3'd0;
  localparam logic [2:0] REG_BASE_LINEAR = 3'd1;
  localparam logic [2:0] REG_STACK_ANCH  = 3'd2;
  localparam logic [2:0] REG_LIM_ARCHIVE = 3'd3;
  localparam logic [2:0] REG_LIM_SCENE   = 3'd4;
  localparam logic [2:0] REG_LIM_TRANS   = 3'd5;
  localparam logic [2:0] REG_LIM_LINEAR  = 3'd6;
  localparam logic [2:0] REG_LIN_RESERVE = 3'd7;

  localparam logic [31:0] RST_LIM_ARCHIVE = 32'd16777216;
  localparam logic [31:0] RST_LIM_SCENE   = 32'd16777216;
  localparam logic [31:0] RST_LIM_TRANS   = 32'd4194304;
  localparam logic [31:0] RST_LIM_LINEAR  = 32'd8388608;
  localparam logic [31:0] RST_LIN_RESERVE = 32'd1048576;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  mem_class;
    logic [31:0] request_size;
    logic [31:0] app_free_now;
    logic [31:0] linear_free_now;
    logic [31:0] stack_pointer_now;
    logic        backing_alloc_ok;
    logic        handle_present;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic        pressure;
    logic [31:0] failure_count;
    logic        app_measure_ok;
    logic [31:0] app_used;
    logic [31:0] app_used_peak;
    logic [31:0] linear_bytes;
    logic [31:0] linear_bytes_peak;
    logic [31:0] stack_depth;
    logic [31:0] stack_depth_peak;
    logic [31:0] class_bytes;
    logic [31:0] class_bytes_peak;
  } out_item_t;

  typedef struct packed {
    logic [31:0] baseline_app_free;
    logic [31:0] baseline_lin_free;
    logic [31:0] stack_origin;
    logic [31:0] limit_archive;
    logic [31:0] limit_scene;
    logic [31:0] limit_transient;
    logic [31:0] limit_linear;
    logic [31:0] linear_reserve;
  } cfg_t;

  // Monitor state as it stands after the item in flight.
  typedef struct packed {
    logic        pressure;
    logic [31:0] failure_count;
    logic        app_ok;
    logic [31:0] app_used;
    logic [31:0] app_peak;
    logic [31:0] lin_used;
    logic [31:0] lin_peak;
    logic [31:0] stk_used;
    logic [31:0] stk_peak;
  } mon_t;

  typedef struct packed {
    logic [31:0] peak;
    logic [31:0] used;
  } store_t;

endpackage

// ===== src/mbam_ram.sv =====
`timescale 1ns / 1ps

module mbam_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mbam_regs.sv =====
`timescale 1ns / 1ps

module mbam_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbam_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output mbam_pkg::cfg_t               cfg
);

  mbam_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.baseline_app_free <= '0;
      cfg_r.baseline_lin_free <= '0;
      cfg_r.stack_origin      <= '0;
      cfg_r.limit_archive     <= mbam_pkg::RST_LIM_ARCHIVE;
      cfg_r.limit_scene       <= mbam_pkg::RST_LIM_SCENE;
      cfg_r.limit_transient   <= mbam_pkg::RST_LIM_TRANS;
      cfg_r.limit_linear      <= mbam_pkg::RST_LIM_LINEAR;
      cfg_r.linear_reserve    <= mbam_pkg::RST_LIN_RESERVE;
    end else if (wr) begin
      unique case (idx)
        mbam_pkg::REG_BASE_APP:    cfg_r.baseline_app_free <= pwdata;
        mbam_pkg::REG_BASE_LINEAR: cfg_r.baseline_lin_free <= pwdata;
        mbam_pkg::REG_STACK_ANCH:  cfg_r.stack_origin      <= pwdata;
        mbam_pkg::REG_LIM_ARCHIVE: cfg_r.limit_archive     <= pwdata;
        mbam_pkg::REG_LIM_SCENE:   cfg_r.limit_scene       <= pwdata;
        mbam_pkg::REG_LIM_TRANS:   cfg_r.limit_transient   <= pwdata;
        mbam_pkg::REG_LIM_LINEAR:  cfg_r.limit_linear      <= pwdata;
        mbam_pkg::REG_LIN_RESERVE: cfg_r.linear_reserve    <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mbam_pkg::REG_BASE_APP:    prdata = cfg_r.baseline_app_free;
      mbam_pkg::REG_BASE_LINEAR: prdata = cfg_r.baseline_lin_free;
      mbam_pkg::REG_STACK_ANCH:  prdata = cfg_r.stack_origin;
      mbam_pkg::REG_LIM_ARCHIVE: prdata = cfg_r.limit_archive;
      mbam_pkg::REG_LIM_SCENE:   prdata = cfg_r.limit_scene;
      mbam_pkg::REG_LIM_TRANS:   prdata = cfg_r.limit_transient;
      mbam_pkg::REG_LIM_LINEAR:  prdata = cfg_r.limit_linear;
      mbam_pkg::REG_LIN_RESERVE: prdata = cfg_r.linear_reserve;
    endcase
  end

endmodule

// ===== src/mbam_sample.sv =====
`timescale 1ns / 1ps

module mbam_sample (
  input  logic               clk,
  input  logic               rst_n,
  input  mbam_pkg::cfg_t     cfg,
  input  mbam_pkg::in_item_t item,
  input  logic               do_sample,
  input  logic               do_fail,
  input  logic               commit,
  output logic               app_ok_now,
  output mbam_pkg::mon_t     mon_nxt
);

  mbam_pkg::mon_t mon_r;
  logic [31:0]    app_drop;
  logic [31:0]    lin_drop;
  logic [31:0]    stk_dist;
  logic           hot;

  assign app_ok_now = (cfg.baseline_app_free != '0) && (item.app_free_now != '0);

  always_comb begin
    app_drop = (item.app_free_now < cfg.baseline_app_free) ?
               cfg.baseline_app_free - item.app_free_now : '0;
    lin_drop = (item.linear_free_now < cfg.baseline_lin_free) ?
               cfg.baseline_lin_free - item.linear_free_now : '0;
    stk_dist = (cfg.stack_origin > item.stack_pointer_now) ?
               cfg.stack_origin - item.stack_pointer_now :
               item.stack_pointer_now - cfg.stack_origin;

    mon_nxt = mon_r;
    if (do_sample) begin
      mon_nxt.app_ok = app_ok_now;
      if (app_ok_now) begin
        mon_nxt.app_used = app_drop;
        if (app_drop > mon_r.app_peak) begin
          mon_nxt.app_peak = app_drop;
        end
      end
      mon_nxt.lin_used = lin_drop;
      if (lin_drop > mon_r.lin_peak) begin
        mon_nxt.lin_peak = lin_drop;
      end
      mon_nxt.stk_used = stk_dist;
      if (stk_dist > mon_r.stk_peak) begin
        mon_nxt.stk_peak = stk_dist;
      end
    end

    // The stack test uses the peak as it stands after this sample.
    hot = (app_ok_now && (item.app_free_now < mbam_pkg::APP_RESERVE)) ||
          (item.linear_free_now < cfg.linear_reserve) ||
          (mon_nxt.stk_peak > mbam_pkg::STACK_LIMIT);
    mon_nxt.pressure = mon_r.pressure || (do_sample && hot) || do_fail;

    if (do_fail && (mon_r.failure_count != mbam_pkg::COUNT_MAX)) begin
      mon_nxt.failure_count = mon_r.failure_count + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_r <= '0;
    end else if (commit) begin
      mon_r <= mon_nxt;
    end
  end

endmodule

// ===== src/memory_budget_admission_monitor_top.sv =====
`timescale 1ns / 1ps

// Memory-quota admission monitor.
// Items arrive on the in_ channel (valid/ready) as sample, alloc or free
// operations with the current free-memory and stack measurements; each item
// yields exactly one result beat on the out_ channel, carrying the grant
// decision, the sticky pressure flag, the failure count and the used/peak
// figures. Quotas, baselines and reserves sit in an APB register bank.
// On acceptance the read of the class entry is issued to the class store RAM;
// in the execute state the quota is checked, the entry is written back and the
// output register is loaded. The next item is accepted only after this one has
// committed, and each item makes a single RAM read-modify-write.
// If the receiver stalls, the result waits in the output register and the
// next item may still be accepted; that item then holds in the execute state
// until the output register is taken.
// Reset clears all counters, peaks and flags and restores the register
// defaults; class entries are marked empty by per-entry valid bits, so no
// clearing pass is needed and items are accepted straight after reset.
module memory_budget_admission_monitor_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mbam_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mbam_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbam_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t              state_r;
  mbam_pkg::in_item_t  item_r;
  mbam_pkg::out_item_t out_r;
  logic                out_valid_r;
  logic [mbam_pkg::NUM_CLASSES-1:0] vld_r;

  mbam_pkg::cfg_t      cfg;
  mbam_pkg::mon_t      mon_nxt;
  mbam_pkg::store_t    rd_word;
  mbam_pkg::store_t    entry;
  mbam_pkg::store_t    wr_word;
  logic [mbam_pkg::CLS_AW-1:0] cls_addr;

  logic        accept;
  logic        commit;
  logic        app_ok_now;
  logic        cls_valid;
  logic [31:0] quota;
  logic [32:0] sum;
  logic        res_ok;
  logic        admit;
  logic        is_alloc;
  logic        free_hit;
  logic        do_sample;
  logic        do_fail;
  logic        granted;
  logic        store_we;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign commit    = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  mbam_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbam_ram #(
    .WIDTH ($bits(mbam_pkg::store_t)),
    .DEPTH (mbam_pkg::NUM_CLASSES)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (cls_addr),
    .wdata (wr_word),
    .re    (accept),
    .raddr (in_data.mem_class[mbam_pkg::CLS_AW-1:0]),
    .rdata (rd_word)
  );

  mbam_sample u_sample (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item       (item_r),
    .do_sample  (do_sample),
    .do_fail    (do_fail),
    .commit     (commit),
    .app_ok_now (app_ok_now),
    .mon_nxt    (mon_nxt)
  );

  assign cls_addr  = item_r.mem_class[mbam_pkg::CLS_AW-1:0];
  assign cls_valid = {1'b0, item_r.mem_class} < 4'(mbam_pkg::NUM_CLASSES);
  assign entry     = vld_r[cls_addr] ? rd_word : '0;

  always_comb begin
    unique case (item_r.mem_class)
      3'd0:    quota = cfg.limit_archive;
      3'd1:    quota = cfg.limit_scene;
      3'd2:    quota = cfg.limit_transient;
      3'd3:    quota = cfg.limit_linear;
      default: quota = '0;
    endcase
  end

  always_comb begin
    sum = {1'b0, entry.used} + {1'b0, item_r.request_size};

    if (item_r.mem_class == mbam_pkg::LINEAR_CLASS) begin
      res_ok = (item_r.linear_free_now >= cfg.linear_reserve) &&
               (item_r.request_size <= item_r.linear_free_now - cfg.linear_reserve);
    end else if (!app_ok_now) begin
      res_ok = 1'b1;
    end else begin
      res_ok = (item_r.app_free_now >= mbam_pkg::APP_RESERVE) &&
               (item_r.request_size <= item_r.app_free_now - mbam_pkg::APP_RESERVE);
    end

    // An overflowing sum shows in the carry bit and also exceeds any quota.
    admit = cls_valid && (item_r.request_size != '0) && !sum[32] &&
            (sum <= {1'b0, quota}) && res_ok && item_r.backing_alloc_ok;

    is_alloc  = (item_r.op == mbam_pkg::OP_ALLOC);
    free_hit  = (item_r.op == mbam_pkg::OP_FREE) && item_r.handle_present && cls_valid;
    do_sample = (item_r.op == mbam_pkg::OP_SAMPLE) || is_alloc || free_hit;
    granted   = is_alloc && admit;
    do_fail   = is_alloc && !admit;

    wr_word = entry;
    if (granted) begin
      wr_word.used = sum[31:0];
      if (sum[31:0] > entry.peak) begin
        wr_word.peak = sum[31:0];
      end
    end else if (free_hit) begin
      wr_word.used = (item_r.request_size < entry.used) ?
                     entry.used - item_r.request_size : '0;
    end

    store_we = commit && (granted || free_hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            item_r  <= in_data;
            state_r <= ST_EXEC;
          end
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            out_r.granted           <= granted;
            out_r.pressure          <= mon_nxt.pressure;
            out_r.failure_count     <= mon_nxt.failure_count;
            out_r.app_measure_ok    <= mon_nxt.app_ok;
            out_r.app_used          <= mon_nxt.app_used;
            out_r.app_used_peak     <= mon_nxt.app_peak;
            out_r.linear_bytes      <= mon_nxt.lin_used;
            out_r.linear_bytes_peak <= mon_nxt.lin_peak;
            out_r.stack_depth       <= mon_nxt.stk_used;
            out_r.stack_depth_peak  <= mon_nxt.stk_peak;
            out_r.class_bytes       <= cls_valid ? wr_word.used : '0;
            out_r.class_bytes_peak  <= cls_valid ? wr_word.peak : '0;
            out_valid_r             <= 1'b1;
            state_r                 <= ST_IDLE;
            if (store_we) begin
              vld_r[cls_addr] <= 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/mbam_checker.sv =====
`timescale 1ns / 1ps

module mbam_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mbam_pkg::out_item_t out_data
);

  // One item in flight: ready drops straight after an accepted beat.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item was in flight");

  // With the output register empty, the execute state commits the result without waiting.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> ##1 out_valid)
    else $error("result beat missing two cycles after acceptance");

  a_cls_charge_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.class_bytes_peak >= out_data.class_bytes))
    else $error("class peak below class charge");

  a_stack_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.stack_depth_peak >= out_data.stack_depth))
    else $error("stack peak below stack depth");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed or vanished");

endmodule

bind memory_budget_admission_monitor_top mbam_checker u_mbam_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/tb_memory_budget_admission_monitor_top.sv =====
`timescale 1ns / 1ps

module tb_memory_budget_admission_monitor_top;
  import mbam_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BEATS = 500;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the register bank and of the monitor state.
  logic [31:0] cfg_value [8];
  mon_t        tracked;
  logic [31:0] cls_charge [NUM_CLASSES];
  logic [31:0] cls_charge_peak [NUM_CLASSES];

  out_item_t   expected_reports [$];
  out_item_t   want;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  memory_budget_admission_monitor_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[memory_budget_admission_monitor_top] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  task automatic clear_model();
    tracked = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      cls_charge[i] = '0;
      cls_charge_peak[i] = '0;
    end
    cfg_value[REG_BASE_APP]    = '0;
    cfg_value[REG_BASE_LINEAR] = '0;
    cfg_value[REG_STACK_ANCH]  = '0;
    cfg_value[REG_LIM_ARCHIVE] = RST_LIM_ARCHIVE;
    cfg_value[REG_LIM_SCENE]   = RST_LIM_SCENE;
    cfg_value[REG_LIM_TRANS]   = RST_LIM_TRANS;
    cfg_value[REG_LIM_LINEAR]  = RST_LIM_LINEAR;
    cfg_value[REG_LIN_RESERVE] = RST_LIN_RESERVE;
  endtask

  function automatic logic [31:0] shortfall(input logic [31:0] base, input logic [31:0] now);
    return (now < base) ? base - now : 32'd0;
  endfunction

  function automatic logic [31:0] quota_of(input logic [2:0] cls);
    // The four quota registers sit in class order from the archive limit upward.
    if (cls <= LINEAR_CLASS) return cfg_value[REG_LIM_ARCHIVE + cls];
    return 32'd0;
  endfunction

  task automatic take_measurements(input logic [31:0] app_now, input logic [31:0] lin_now,
                                   input logic [31:0] sp);
    logic        hot;
    logic [31:0] anchor;
    anchor = cfg_value[REG_STACK_ANCH];
    tracked.app_ok = (cfg_value[REG_BASE_APP] != 0) && (app_now != 0);
    if (tracked.app_ok) begin
      tracked.app_used = shortfall(cfg_value[REG_BASE_APP], app_now);
      if (tracked.app_used > tracked.app_peak) tracked.app_peak = tracked.app_used;
    end
    tracked.lin_used = shortfall(cfg_value[REG_BASE_LINEAR], lin_now);
    if (tracked.lin_used > tracked.lin_peak) tracked.lin_peak = tracked.lin_used;
    tracked.stk_used = (anchor > sp) ? anchor - sp : sp - anchor;
    if (tracked.stk_used > tracked.stk_peak) tracked.stk_peak = tracked.stk_used;
    hot = (tracked.app_ok && app_now < APP_RESERVE) ||
          (lin_now < cfg_value[REG_LIN_RESERVE]) ||
          (tracked.stk_peak > STACK_LIMIT);
    tracked.pressure = tracked.pressure | hot;
  endtask

  function automatic logic may_admit(input logic [2:0] cls, input logic [31:0] size,
                                     input logic [31:0] app_now, input logic [31:0] lin_now);
    logic [32:0] total;
    logic [31:0] reserve;
    if (cls >= NUM_CLASSES || size == 0) return 1'b0;
    total = {1'b0, cls_charge[cls]} + {1'b0, size};
    if (total[32] || total > {1'b0, quota_of(cls)}) return 1'b0;
    reserve = cfg_value[REG_LIN_RESERVE];
    if (cls == LINEAR_CLASS) return (lin_now >= reserve) && (size <= lin_now - reserve);
    if (!tracked.app_ok) return 1'b1;
    return (app_now >= APP_RESERVE) && (size <= app_now - APP_RESERVE);
  endfunction

  task automatic predict_admission(input in_item_t it);
    out_item_t rep;
    logic      class_ok;
    logic      granted;
    class_ok = it.mem_class < NUM_CLASSES;
    granted  = 1'b0;
    case (it.op)
      OP_SAMPLE: begin
        take_measurements(it.app_free_now, it.linear_free_now, it.stack_pointer_now);
      end
      OP_ALLOC: begin
        take_measurements(it.app_free_now, it.linear_free_now, it.stack_pointer_now);
        if (may_admit(it.mem_class, it.request_size, it.app_free_now, it.linear_free_now) &&
            it.backing_alloc_ok) begin
          cls_charge[it.mem_class] = cls_charge[it.mem_class] + it.request_size;
          if (cls_charge[it.mem_class] > cls_charge_peak[it.mem_class])
            cls_charge_peak[it.mem_class] = cls_charge[it.mem_class];
          granted = 1'b1;
        end else begin
          if (tracked.failure_count != COUNT_MAX)
            tracked.failure_count = tracked.failure_count + 32'd1;
          tracked.pressure = 1'b1;
        end
      end
      OP_FREE: begin
        if (it.handle_present && class_ok) begin
          cls_charge[it.mem_class] = (it.request_size < cls_charge[it.mem_class]) ?
                                     cls_charge[it.mem_class] - it.request_size : 32'd0;
          take_measurements(it.app_free_now, it.linear_free_now, it.stack_pointer_now);
        end
      end
      default: begin
      end
    endcase
    rep.granted           = granted;
    rep.pressure          = tracked.pressure;
    rep.failure_count     = tracked.failure_count;
    rep.app_measure_ok    = tracked.app_ok;
    rep.app_used          = tracked.app_used;
    rep.app_used_peak     = tracked.app_peak;
    rep.linear_bytes      = tracked.lin_used;
    rep.linear_bytes_peak = tracked.lin_peak;
    rep.stack_depth       = tracked.stk_used;
    rep.stack_depth_peak  = tracked.stk_peak;
    rep.class_bytes       = class_ok ? cls_charge[it.mem_class] : 32'd0;
    rep.class_bytes_peak  = class_ok ? cls_charge_peak[it.mem_class] : 32'd0;
    expected_reports.push_back(rep);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      if (mismatch_count < 10)
        $display("mismatch in %s: expected %h, got %h", field, exp_val, got_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        if (mismatch_count < 10) $display("result beat with nothing expected: %h", out_data);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        compare_field("granted", 32'(want.granted), 32'(out_data.granted));
        compare_field("pressure", 32'(want.pressure), 32'(out_data.pressure));
        compare_field("failure_count", want.failure_count, out_data.failure_count);
        compare_field("app_measure_ok", 32'(want.app_measure_ok),
                      32'(out_data.app_measure_ok));
        compare_field("app_used", want.app_used, out_data.app_used);
        compare_field("app_used_peak", want.app_used_peak, out_data.app_used_peak);
        compare_field("linear_bytes", want.linear_bytes, out_data.linear_bytes);
        compare_field("linear_bytes_peak", want.linear_bytes_peak, out_data.linear_bytes_peak);
        compare_field("stack_depth", want.stack_depth, out_data.stack_depth);
        compare_field("stack_depth_peak", want.stack_depth_peak, out_data.stack_depth_peak);
        compare_field("class_bytes", want.class_bytes, out_data.class_bytes);
        compare_field("class_bytes_peak", want.class_bytes_peak, out_data.class_bytes_peak);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving; every task here starts and ends on a falling edge.
  // ---------------------------------------------------------------------------

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    predict_admission(it);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    cfg_value[idx] = value;
  endtask

  task automatic apply_settings(input cfg_t s);
    write_reg(REG_BASE_APP, s.baseline_app_free);
    write_reg(REG_BASE_LINEAR, s.baseline_lin_free);
    write_reg(REG_STACK_ANCH, s.stack_origin);
    write_reg(REG_LIM_ARCHIVE, s.limit_archive);
    write_reg(REG_LIM_SCENE, s.limit_scene);
    write_reg(REG_LIM_TRANS, s.limit_transient);
    write_reg(REG_LIM_LINEAR, s.limit_linear);
    write_reg(REG_LIN_RESERVE, s.linear_reserve);
  endtask

  // Registers are only touched once every outstanding result has been taken.
  task automatic settle();
    in_valid = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic in_item_t compose(input logic [1:0] op, input logic [2:0] cls,
                                       input logic [31:0] size, input logic [31:0] app_now,
                                       input logic [31:0] lin_now, input logic [31:0] sp,
                                       input logic backing, input logic handle);
    in_item_t it;
    it.op                = op;
    it.mem_class         = cls;
    it.request_size      = size;
    it.app_free_now      = app_now;
    it.linear_free_now   = lin_now;
    it.stack_pointer_now = sp;
    it.backing_alloc_ok  = backing;
    it.handle_present    = handle;
    return it;
  endfunction

  // Mostly plausible traffic around the programmed baselines, with some noise.
  function automatic in_item_t random_item();
    in_item_t    it;
    int          pick;
    logic [31:0] base;
    logic [31:0] span;
    logic [31:0] d;
    if ($urandom_range(99) < 12) begin
      it.op                = 2'($urandom_range(3));
      it.mem_class         = 3'($urandom_range(7));
      it.request_size      = $urandom;
      it.app_free_now      = $urandom;
      it.linear_free_now   = $urandom;
      it.stack_pointer_now = $urandom;
      it.backing_alloc_ok  = 1'($urandom_range(1));
      it.handle_present    = 1'($urandom_range(1));
      return it;
    end
    pick  = $urandom_range(99);
    it.op = (pick < 25) ? OP_SAMPLE : (pick < 70) ? OP_ALLOC : OP_FREE;
    it.mem_class = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 4)) :
                                               3'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 3) it.request_size = 32'd0;
    else if (pick < 70) it.request_size = $urandom_range(1 << 20, 1);
    else if (pick < 92) it.request_size = $urandom_range(1 << 24, 1);
    else it.request_size = $urandom;

    base = cfg_value[REG_BASE_APP];
    pick = $urandom_range(99);
    if (pick < 5) it.app_free_now = 32'd0;
    else if (pick < 15) it.app_free_now = $urandom_range(2 * APP_RESERVE);
    else if (base == 0) it.app_free_now = $urandom_range(1 << 26, 1);
    else begin
      span = (base < (1 << 25)) ? base : (1 << 25);
      it.app_free_now = base - $urandom_range(span, 0);
    end

    base = cfg_value[REG_BASE_LINEAR];
    pick = $urandom_range(99);
    if (pick < 10) it.linear_free_now = $urandom_range(1 << 21);
    else if (base == 0) it.linear_free_now = $urandom_range(1 << 25);
    else begin
      span = (base < (1 << 24)) ? base : (1 << 24);
      it.linear_free_now = base - $urandom_range(span, 0);
    end

    d = $urandom_range(1 << 17);
    it.stack_pointer_now = $urandom_range(1) ? cfg_value[REG_STACK_ANCH] + d :
                                               cfg_value[REG_STACK_ANCH] - d;
    it.backing_alloc_ok = ($urandom_range(9) != 0);
    it.handle_present   = ($urandom_range(9) != 0);
    return it;
  endfunction

  task automatic run_random(input int beats);
    repeat (beats) send_item(random_item());
    in_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    logic [31:0] anchor;
    logic [31:0] app_now;
    logic [31:0] lin_now;
    anchor  = 32'h0010_0000;
    app_now = 32'h0300_0000;
    lin_now = 32'h0180_0000;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle();
    write_reg(REG_BASE_APP, 32'h0400_0000);
    write_reg(REG_BASE_LINEAR, 32'h0200_0000);
    write_reg(REG_STACK_ANCH, anchor);
    // Samples that stay clear of every pressure condition, then a deep stack.
    send_item(compose(OP_SAMPLE, 3'd0, 32'd0, 32'd0, lin_now, anchor - 32'h100, 1'b1, 1'b1));
    send_item(compose(OP_SAMPLE, 3'd1, 32'd0, app_now, lin_now, anchor + 32'h200, 1'b1, 1'b1));
    send_item(compose(OP_SAMPLE, 3'd2, 32'd0, '1, '1, anchor, 1'b1, 1'b1));
    send_item(compose(OP_SAMPLE, 3'd3, 32'd0, app_now, lin_now, anchor + 32'h2_0000, 1'b1, 1'b1));
    // Allocation checks: zero size, invalid classes, exact quota and reserve edges.
    send_item(compose(OP_ALLOC, 3'd0, 32'd1, app_now, lin_now, anchor, 1'b1, 1'b1));
    send_item(compose(OP_ALLOC, 3'd1, 32'd0, app_now, lin_now, anchor, 1'b1, 1'b1));
    send_item(compose(OP_ALLOC, 3'd4, 32'h10, app_now, lin_now, anchor, 1'b1, 1'b1));
    send_item(compose(OP_ALLOC, 3'd7, 32'h10, app_now, lin_now, anchor, 1'b1, 1'b1));
    send_item(compose(OP_ALLOC, 3'd2, RST_LIM_TRANS, app_now, lin_now, anchor, 1'b1, 1'b1));
    send_item(compose(OP_ALLOC, 3'd2, 32'd1, app_now, lin_now, anchor, 1'b1, 1'b1));
    send_item(compose(OP_ALLOC, LINEAR_CLASS, 32'h1000, app_now, lin_now, anchor, 1'b1, 1'b1));
    send_item(compose(OP_ALLOC, LINEAR_CLASS, 32'h10, app_now, 32'h000F_FFFF, anchor,
                      1'b1, 1'b1));
    send_item(compose(OP_ALLOC, LINEAR_CLASS, 32'h0020_0000, app_now, 32'h0030_0000, anchor,
                      1'b1, 1'b1));
    send_item(compose(OP_ALLOC, 3'd1, 32'h10, 32'h000F_FFFF, lin_now, anchor, 1'b1, 1'b1));
    send_item(compose(OP_ALLOC, 3'd1, 32'h0010_0000, 32'h0020_0000, lin_now, anchor,
                      1'b1, 1'b1));
    send_item(compose(OP_ALLOC, 3'd1, 32'h0010_0001, 32'h0020_0000, lin_now, anchor,
                      1'b1, 1'b1));
    send_item(compose(OP_ALLOC, 3'd0, 32'h100, app_now, lin_now, anchor, 1'b0, 1'b1));
    // With no application measurement only the quota limits the request.
    send_item(compose(OP_ALLOC, 3'd0, 32'h00F0_0000, 32'd0, lin_now, anchor, 1'b1, 1'b1));
    // Releases: no handle, invalid class, partial, and one that floors at zero.
    send_item(compose(OP_FREE, 3'd0, 32'h10, app_now, lin_now, anchor + 32'h3_0000, 1'b1, 1'b0));
    send_item(compose(OP_FREE, 3'd6, 32'h10, app_now, lin_now, anchor + 32'h3_0000, 1'b1, 1'b1));
    send_item(compose(OP_FREE, 3'd0, 32'h10, app_now, lin_now, anchor, 1'b0, 1'b1));
    send_item(compose(OP_FREE, 3'd2, '1, app_now, lin_now, anchor, 1'b1, 1'b1));
    send_item(compose(OP_RESERVED, 3'd5, $urandom, $urandom, $urandom, $urandom, 1'b1, 1'b1));
    send_item(compose(OP_SAMPLE, 3'd0, 32'd0, app_now, lin_now, 32'd0, 1'b1, 1'b1));
    send_item(compose(OP_SAMPLE, 3'd0, 32'd0, app_now, lin_now, '1, 1'b1, 1'b1));
    in_valid = 1'b0;
  endtask

  task automatic test_class_overflow();
    logic [31:0] lin_now;
    lin_now = 32'h0180_0000;
    settle();
    write_reg(REG_BASE_APP, 32'd0);
    write_reg(REG_LIM_ARCHIVE, '1);
    send_item(compose(OP_ALLOC, 3'd0, 32'hF000_0000, 32'd0, lin_now, 32'd0, 1'b1, 1'b1));
    // The sum no longer fits in 32 bits.
    send_item(compose(OP_ALLOC, 3'd0, 32'h2000_0000, 32'd0, lin_now, 32'd0, 1'b1, 1'b1));
    // Fill the class to exactly all ones, then one byte more.
    send_item(compose(OP_ALLOC, 3'd0, ~cls_charge[0], 32'd0, lin_now, 32'd0, 1'b1, 1'b1));
    send_item(compose(OP_ALLOC, 3'd0, 32'd1, 32'd0, lin_now, 32'd0, 1'b1, 1'b1));
    send_item(compose(OP_FREE, 3'd0, '1, 32'd0, lin_now, 32'd0, 1'b1, 1'b1));
    in_valid = 1'b0;
  endtask

  task automatic test_random_no_idling();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle();
    apply_settings('{32'h0800_0000, 32'h0400_0000, 32'h2000_0000, RST_LIM_ARCHIVE,
                     RST_LIM_SCENE, RST_LIM_TRANS, RST_LIM_LINEAR, RST_LIN_RESERVE});
    run_random(RANDOM_BEATS);
  endtask

  task automatic test_random_sender_gaps();
    send_idle_pct  = 46;
    recv_stall_pct = 0;
    settle();
    apply_settings('{'1, '1, '1, '1, '1, '1, '1, 32'd0});
    run_random(RANDOM_BEATS);
  endtask

  task automatic test_random_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    settle();
    apply_settings('{32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'h1000, 32'h0010_0000, '1});
    run_random(RANDOM_BEATS);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    settle();
    apply_settings('{$urandom_range(1 << 30, 1 << 22), $urandom_range(1 << 30, 1 << 22),
                     $urandom, $urandom_range(1 << 26, 1 << 16), $urandom_range(1 << 26, 1 << 16),
                     $urandom_range(1 << 26, 1 << 16), $urandom_range(1 << 26, 1 << 16),
                     $urandom_range(1 << 22)});
    run_random(RANDOM_BEATS);
  endtask

  initial begin
    clear_model();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_cases();
    test_class_overflow();
    test_random_no_idling();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();
    settle();
    if (mismatch_count == 0) begin
      $display("[memory_budget_admission_monitor_top] OK");
    end else begin
      $display("[memory_budget_admission_monitor_top] ERROR");
    end
    $finish;
  end

endmodule
